// ----- rtl/core/rid_pkg.sv -----
// Shared types, constants and scaling helpers for the reverse impact detector.
package rid_pkg;

  localparam int unsigned SPEED_DEPTH_DEF = 10;
  localparam int unsigned ACCEL_DEPTH_DEF = 100;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned REG_DATA_W = 32;

  localparam logic signed [15:0] SPEED_LIMIT_RST = -16'sd256;

  // floor(t / 5) == (t * 52429) >> 18 for every t below 2^18
  localparam logic [15:0] RECIP_5 = 16'd52429;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPEED = 2'd0,
    CMD_ACCEL = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PEAK_X      = 2'd0,
    REG_Z_SPREAD    = 2'd1,
    REG_HOLD        = 2'd2,
    REG_SPEED_LIMIT = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  // first half of the g -> m/s^2 scaling: sign and (|g*49| + 40) >> 4
  typedef struct packed {
    logic        neg;
    logic [16:0] t;
  } scale_pre_t;

  // one window entry handed to the scan unit
  typedef struct packed {
    logic en;
    logic first;
    logic acc_en;
    logic acc_ok;
    logic spd_en;
  } scan_ctl_t;

  function automatic scale_pre_t scale_pre(input logic signed [15:0] g);
    logic signed [21:0] n;
    logic [20:0]        mag;
    logic [20:0]        rnd;
    scale_pre_t         r;
    n     = (22'(g) <<< 5) + (22'(g) <<< 4) + 22'(g);
    mag   = n[21] ? 21'(-n) : n[20:0];
    rnd   = mag + 21'd40;
    r.neg = n[21];
    r.t   = rnd[20:4];
    return r;
  endfunction

  function automatic logic signed [15:0] scale_post(input scale_pre_t p);
    logic [32:0] prod;
    logic [14:0] q;
    prod = 33'(p.t) * 33'(RECIP_5);
    // quotient stays below 2^15, so the result never saturates
    q    = prod[32:18];
    return p.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ----- rtl/core/rid_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rid_scan.sv -----
// Shared scan unit: one window entry per cycle, while enabled, into sum, x max, z max and z min.
module rid_scan #(
  parameter int unsigned SUM_W = 20
) (
  input  logic                    clk_i,
  input  rid_pkg::scan_ctl_t      ctl_i,
  input  logic signed [15:0]      x_i,
  input  logic signed [15:0]      z_i,
  input  logic signed [15:0]      spd_i,
  output logic signed [SUM_W-1:0] sum_o,
  output logic signed [15:0]      xmax_o,
  output logic signed [15:0]      zmax_o,
  output logic signed [15:0]      zmin_o
);

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [15:0]      xmax_q, xmax_d;
  logic signed [15:0]      zmax_q, zmax_d;
  logic signed [15:0]      zmin_q, zmin_d;
  logic signed [15:0]      x_v, z_v;
  logic signed [SUM_W-1:0] spd_v;

  // entries never written read as zero
  assign x_v   = ctl_i.acc_ok ? x_i : 16'sd0;
  assign z_v   = ctl_i.acc_ok ? z_i : 16'sd0;
  assign spd_v = ctl_i.spd_en ? SUM_W'(spd_i) : '0;

  always_comb begin
    sum_d  = sum_q;
    xmax_d = xmax_q;
    zmax_d = zmax_q;
    zmin_d = zmin_q;
    if (ctl_i.first) begin
      sum_d  = spd_v;
      xmax_d = x_v;
      zmax_d = z_v;
      zmin_d = z_v;
    end else begin
      sum_d = sum_q + spd_v;
      if (ctl_i.acc_en) begin
        if (x_v > xmax_q) xmax_d = x_v;
        if (z_v > zmax_q) zmax_d = z_v;
        if (z_v < zmin_q) zmin_d = z_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sum_q  <= sum_d;
      xmax_q <= xmax_d;
      zmax_q <= zmax_d;
      zmin_q <= zmin_d;
    end
  end

  assign sum_o  = sum_q;
  assign xmax_o = xmax_q;
  assign zmax_o = zmax_q;
  assign zmin_o = zmin_q;

endmodule

// ----- rtl/core/reverse_impact_detector_unit.sv -----
// Reverse impact detector: sample windows, sequencer, decision and output register.
// Velocity item: written at accept. Acceleration item: scale prefix at accept, store next
// (state STORE). Evaluate item: states SCAN, DRAIN and DECIDE, one window entry per cycle
// through the single RAM read port in SCAN; DECIDE waits until the output register is free.
// Reset (async, active low) clears control, configuration, velocity window, slots, fill count,
// flag and onset time; unwritten acceleration entries read as zero through the fill count.
module reverse_impact_detector_unit #(
  parameter int unsigned SPEED_DEPTH = rid_pkg::SPEED_DEPTH_DEF,
  parameter int unsigned ACCEL_DEPTH = rid_pkg::ACCEL_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] speed_sample, [31:16] accel_x_g, [47:32] accel_z_g, [79:48] now_ms
  input  logic [rid_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [rid_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] impact_flag, [16:1] peak_x, [32:17] z_spread, [52:33] speed_sum, [55:53] zero
  output logic [rid_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [rid_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rid_pkg::REG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned SCAN_N = (SPEED_DEPTH > ACCEL_DEPTH) ? SPEED_DEPTH : ACCEL_DEPTH;
  localparam int unsigned CNT_W  = $clog2(SCAN_N + 1);
  localparam int unsigned AW     = (ACCEL_DEPTH > 1) ? $clog2(ACCEL_DEPTH) : 1;
  localparam int unsigned SW     = (SPEED_DEPTH > 1) ? $clog2(SPEED_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(ACCEL_DEPTH + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(SPEED_DEPTH);
  localparam int unsigned LIM_W  = 16 + $clog2(SPEED_DEPTH + 1);
  localparam logic signed [LIM_W-1:0] SD_S = LIM_W'(SPEED_DEPTH);

  // configuration
  logic signed [15:0] peak_thr_q;
  logic [15:0]        zspread_thr_q;
  logic [31:0]        hold_q;
  logic signed [15:0] limit_q;

  // state
  rid_pkg::state_e    state_q, state_d;
  logic signed [15:0] speed_win_q [SPEED_DEPTH];
  logic [SW-1:0]      spd_slot_q;
  logic [AW-1:0]      acc_slot_q;
  logic [FILL_W-1:0]  fill_q;
  logic               detected_q;
  logic [31:0]        onset_q;
  logic [31:0]        now_q;
  logic [CNT_W-1:0]   cnt_q;
  rid_pkg::scale_pre_t pre_x_q, pre_z_q;
  rid_pkg::scan_ctl_t ctl_q, ctl_d;
  logic signed [15:0] spd_q, spd_d;
  logic [rid_pkg::OUT_DATA_W-1:0] out_q, out_d;
  logic               m_valid_q;

  // control
  logic               s_acc;
  rid_pkg::cmd_e      cmd;
  logic               out_free;
  logic               ram_we;
  logic               issue;
  logic               load_out;

  // datapath
  logic [31:0]        ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0] sum;
  logic signed [15:0] xmax, zmax, zmin;
  logic signed [16:0] zdiff;
  logic [15:0]        spread;
  logic signed [LIM_W-1:0] sum_cmp, lim_prod;
  logic signed [31:0] sum_ext;
  logic               cond;
  logic [31:0]        elapsed;
  logic               det_d;
  logic [31:0]        onset_d;

  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign cmd      = rid_pkg::cmd_e'(s_axis_tuser);
  assign out_free = !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rid_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (cmd)
            rid_pkg::CMD_ACCEL: state_d = rid_pkg::ST_STORE;
            rid_pkg::CMD_EVAL:  state_d = rid_pkg::ST_SCAN;
            default:            state_d = rid_pkg::ST_IDLE;
          endcase
        end
      end
      rid_pkg::ST_STORE: state_d = rid_pkg::ST_IDLE;
      rid_pkg::ST_SCAN: begin
        if (cnt_q == CNT_W'(SCAN_N - 1)) state_d = rid_pkg::ST_DRAIN;
      end
      rid_pkg::ST_DRAIN: state_d = rid_pkg::ST_DECIDE;
      rid_pkg::ST_DECIDE: begin
        if (out_free) state_d = rid_pkg::ST_IDLE;
      end
      default: state_d = rid_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      rid_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      rid_pkg::ST_STORE:  ram_we        = 1'b1;
      rid_pkg::ST_SCAN:   issue         = 1'b1;
      rid_pkg::ST_DECIDE: load_out      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q    <= '0;
      zspread_thr_q <= '0;
      hold_q        <= '0;
      limit_q       <= rid_pkg::SPEED_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rid_pkg::REG_PEAK_X:      peak_thr_q    <= cfg_data_i[15:0];
        rid_pkg::REG_Z_SPREAD:    zspread_thr_q <= cfg_data_i[15:0];
        rid_pkg::REG_HOLD:        hold_q        <= cfg_data_i;
        rid_pkg::REG_SPEED_LIMIT: limit_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // velocity window, written straight at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SPEED_DEPTH; i++) speed_win_q[i] <= '0;
      spd_slot_q <= '0;
    end else if (s_acc && cmd == rid_pkg::CMD_SPEED) begin
      speed_win_q[spd_slot_q] <= s_axis_tdata[15:0];
      spd_slot_q <= (spd_slot_q == SW'(SPEED_DEPTH - 1)) ? '0 : spd_slot_q + 1'b1;
    end
  end

  // acceleration: scale prefix registered at accept, quotient in STORE
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pre_x_q <= rid_pkg::scale_pre(s_axis_tdata[31:16]);
      pre_z_q <= rid_pkg::scale_pre(s_axis_tdata[47:32]);
      now_q   <= s_axis_tdata[79:48];
    end
  end

  assign ram_wdata = {rid_pkg::scale_post(pre_z_q), rid_pkg::scale_post(pre_x_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_slot_q <= '0;
      fill_q     <= '0;
    end else if (ram_we) begin
      acc_slot_q <= (acc_slot_q == AW'(ACCEL_DEPTH - 1)) ? '0 : acc_slot_q + 1'b1;
      if (fill_q != FILL_W'(ACCEL_DEPTH)) fill_q <= fill_q + 1'b1;
    end
  end

  rid_ram #(
    .WIDTH (32),
    .DEPTH (ACCEL_DEPTH)
  ) u_accel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (acc_slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // scan sequencing: address issued now, entry reaches the scan unit next cycle
  always_comb begin
    ctl_d.en     = issue;
    ctl_d.first  = (cnt_q == '0);
    ctl_d.acc_en = (cnt_q < CNT_W'(ACCEL_DEPTH));
    ctl_d.acc_ok = (cnt_q < CNT_W'(fill_q));
    ctl_d.spd_en = (cnt_q < CNT_W'(SPEED_DEPTH));
    spd_d        = ctl_d.spd_en ? speed_win_q[cnt_q[SW-1:0]] : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ctl_q <= '0;
    end else begin
      cnt_q <= issue ? cnt_q + 1'b1 : '0;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_q <= spd_d;
  end

  rid_scan #(
    .SUM_W (SUM_W)
  ) u_scan (
    .clk_i  (clk_i),
    .ctl_i  (ctl_q),
    .x_i    (ram_rdata[15:0]),
    .z_i    (ram_rdata[31:16]),
    .spd_i  (spd_q),
    .sum_o  (sum),
    .xmax_o (xmax),
    .zmax_o (zmax),
    .zmin_o (zmin)
  );

  // decision
  assign zdiff    = 17'(zmax) - 17'(zmin);
  assign spread   = zdiff[15:0];
  assign sum_cmp  = LIM_W'(sum);
  assign lim_prod = LIM_W'(limit_q) * SD_S;
  assign sum_ext  = 32'(sum);
  assign elapsed  = now_q - onset_q;
  assign cond     = (sum < 0) && (sum_cmp > lim_prod) &&
                    (xmax > peak_thr_q) && (spread > zspread_thr_q);

  always_comb begin
    det_d   = detected_q;
    onset_d = onset_q;
    if (cond) begin
      if (!detected_q) begin
        det_d   = 1'b1;
        onset_d = now_q;
      end
    end else if (detected_q && elapsed > hold_q) begin
      det_d = 1'b0;
    end
    out_d = {3'b000, sum_ext[19:0], spread, xmax, det_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detected_q <= 1'b0;
      onset_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (load_out) begin
        detected_q <= det_d;
        onset_q    <= onset_d;
        m_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- rtl/core/rid_checker.sv -----
// Port-level checks for the reverse impact detector, bound to the top level.
module rid_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rid_pkg::CMD_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rid_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // velocity and unused items never stall the input
  a_speed_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == rid_pkg::CMD_SPEED || s_axis_tuser == rid_pkg::CMD_NONE)
    |=> s_axis_tready)
    else $error("input stalled after a velocity or unused item");

  // acceleration item holds the input for its store cycle
  a_accel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == rid_pkg::CMD_ACCEL |=> !s_axis_tready)
    else $error("input ready during acceleration store");

  // evaluate closes the input after accept and keeps it closed into the scan
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == rid_pkg::CMD_EVAL |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input ready during evaluation");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind reverse_impact_detector_unit rid_port_checker u_rid_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/rid_checker.sv -----
// Checker for the reverse impact detector: tracks windows, predicts each evaluate result.
module rid_checker #(
  parameter int unsigned SPEED_DEPTH = rid_pkg::SPEED_DEPTH_DEF,
  parameter int unsigned ACCEL_DEPTH = rid_pkg::ACCEL_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  // [15:0] speed_sample, [31:16] accel_x_g, [47:32] accel_z_g, [79:48] now_ms
  input  logic [rid_pkg::IN_DATA_W-1:0]  in_data_i,
  // [1:0] cmd
  input  logic [rid_pkg::CMD_W-1:0]      in_user_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  // [0] impact_flag, [16:1] peak_x, [32:17] z_spread, [52:33] speed_sum, [55:53] zero
  input  logic [rid_pkg::OUT_DATA_W-1:0] out_data_i,
  input  logic                           cfg_we_i,
  input  logic [rid_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rid_pkg::REG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import rid_pkg::*;

  typedef struct packed {
    logic        flag;
    logic [15:0] peak;
    logic [15:0] spread;
    logic [19:0] sum;
  } impact_report_t;

  logic signed [15:0] speed_hist [SPEED_DEPTH];
  logic signed [15:0] ax_hist    [ACCEL_DEPTH];
  logic signed [15:0] az_hist    [ACCEL_DEPTH];
  int unsigned        speed_ptr;
  int unsigned        accel_ptr;
  logic               latched;
  logic [31:0]        onset_ms;
  logic signed [15:0] peak_thr;
  logic [15:0]        spread_thr;
  logic [31:0]        hold_ms;
  logic signed [15:0] speed_limit;
  impact_report_t     report_q [$];

  initial fail_count_o = 0;

  // g in Q4.12 to m/s^2 in Q8.8: *49/80, round half away from zero, saturate
  function automatic logic signed [15:0] g_to_mps2(input logic signed [15:0] g);
    int          n;
    int unsigned mag;
    int unsigned q;
    int          r;
    n   = int'(g) * 49;
    mag = (n < 0) ? -n : n;
    q   = (mag + 40) / 80;
    if (q > 32768) q = 32768;
    r = (n < 0) ? -int'(q) : int'(q);
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  task automatic predict_eval(input logic [31:0] now);
    longint         total;
    int             xmax;
    int             zmax;
    int             zmin;
    int             spread;
    logic [31:0]    elapsed;
    logic           hit;
    impact_report_t rep;
    total = 0;
    foreach (speed_hist[i]) total += speed_hist[i];
    xmax = ax_hist[0];
    zmax = az_hist[0];
    zmin = az_hist[0];
    for (int i = 1; i < ACCEL_DEPTH; i++) begin
      if (ax_hist[i] > xmax) xmax = ax_hist[i];
      if (az_hist[i] > zmax) zmax = az_hist[i];
      if (az_hist[i] < zmin) zmin = az_hist[i];
    end
    spread = zmax - zmin;
    // speed test on the exact sum, never on the truncated output field
    hit = total < 0 && total > longint'(SPEED_DEPTH) * longint'(speed_limit) &&
          xmax > int'(peak_thr) && spread > int'(spread_thr);
    if (hit) begin
      if (!latched) begin
        latched  = 1'b1;
        onset_ms = now;
      end
    end else if (latched) begin
      elapsed = now - onset_ms;
      if (elapsed > hold_ms) latched = 1'b0;
    end
    rep.flag   = latched;
    rep.peak   = xmax[15:0];
    rep.spread = spread[15:0];
    rep.sum    = total[19:0];
    report_q.push_back(rep);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] got);
    impact_report_t want;
    if (report_q.size() == 0) begin
      $error("result item with no evaluate pending: %h", got);
      fail_count_o++;
      return;
    end
    want = report_q.pop_front();
    if (got[0] !== want.flag) begin
      $error("impact_flag: expected %0d, actual %0d", want.flag, got[0]);
      fail_count_o++;
    end
    if (got[16:1] !== want.peak) begin
      $error("peak_x: expected %0d, actual %0d", $signed(want.peak), $signed(got[16:1]));
      fail_count_o++;
    end
    if (got[32:17] !== want.spread) begin
      $error("z_spread: expected %0d, actual %0d", want.spread, got[32:17]);
      fail_count_o++;
    end
    if (got[52:33] !== want.sum) begin
      $error("speed_sum: expected %0d, actual %0d", $signed(want.sum), $signed(got[52:33]));
      fail_count_o++;
    end
    if (got[55:53] !== 3'b000) begin
      $error("pad: expected 0, actual %0d", got[55:53]);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (speed_hist[i]) speed_hist[i] = '0;
      foreach (ax_hist[i]) ax_hist[i] = '0;
      foreach (az_hist[i]) az_hist[i] = '0;
      speed_ptr   = 0;
      accel_ptr   = 0;
      latched     = 1'b0;
      onset_ms    = '0;
      peak_thr    = '0;
      spread_thr  = '0;
      hold_ms     = '0;
      speed_limit = SPEED_LIMIT_RST;
      report_q.delete();
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_PEAK_X:      peak_thr    = cfg_data_i[15:0];
          REG_Z_SPREAD:    spread_thr  = cfg_data_i[15:0];
          REG_HOLD:        hold_ms     = cfg_data_i;
          REG_SPEED_LIMIT: speed_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (cmd_e'(in_user_i))
          CMD_SPEED: begin
            speed_hist[speed_ptr] = in_data_i[15:0];
            speed_ptr = (speed_ptr + 1 >= SPEED_DEPTH) ? 0 : speed_ptr + 1;
          end
          CMD_ACCEL: begin
            ax_hist[accel_ptr] = g_to_mps2(in_data_i[31:16]);
            az_hist[accel_ptr] = g_to_mps2(in_data_i[47:32]);
            accel_ptr = (accel_ptr + 1 >= ACCEL_DEPTH) ? 0 : accel_ptr + 1;
          end
          CMD_EVAL: predict_eval(in_data_i[79:48]);
          default: ;
        endcase
      end
      pending_o = report_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the reverse impact detector: stimulus, idling, watchdog and verdict.
module tb_top;
  import rid_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned PHASE_ITEMS    = 270;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data  = '0;
  logic [CMD_W-1:0]      s_user  = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  cfg_we   = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx  = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;

  int unsigned        chk_fails;
  int unsigned        chk_pending;
  int unsigned        idle_cycles = 0;
  int unsigned        sent = 0;
  bit                 calm = 1'b0;
  logic [31:0]        clock_ms = '0;
  logic [31:0]        cur_hold = '0;
  logic signed [15:0] cur_limit = SPEED_LIMIT_RST;

  always #4 clk_i = ~clk_i;

  reverse_impact_detector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  rid_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending)
  );

  always @(negedge clk_i) m_ready <= calm || ($urandom_range(0, 99) >= 28);

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // returns at the accepting edge with valid still high
  task automatic push_item(input cmd_e cmd, input logic [15:0] spd, input logic [15:0] ax,
                           input logic [15:0] az, input logic [31:0] now);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {now, az, ax, spd};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    if (cmd != CMD_NONE) sent++;
  endtask

  // stop sending, wait for every result, then let sample items finish
  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_config(input int phase);
    logic signed [15:0] peak;
    logic [15:0]        spread;
    logic [31:0]        hold;
    logic signed [15:0] lim;
    case (phase)
      0: begin peak = 16'sd512;   spread = 16'd1024;  hold = 32'd20;         lim = -16'sd256;  end
      1: begin peak = 16'sh7FFF;  spread = 16'hFFFF;  hold = 32'd0;          lim = 16'sd0;     end
      2: begin peak = 16'sh8000;  spread = 16'd0;     hold = 32'hFFFF_FFFF;  lim = 16'sh8000;  end
      3: begin peak = 16'sd0;     spread = 16'd100;   hold = 32'd5;          lim = 16'sd300;   end
      default: begin
        peak   = 16'(int'($urandom_range(0, 8000)) - 2000);
        spread = 16'($urandom_range(0, 20000));
        hold   = $urandom_range(0, 1) ? 32'($urandom_range(0, 60)) : $urandom;
        lim    = 16'(-int'($urandom_range(1, 32768)));
      end
    endcase
    settle();
    write_reg(REG_PEAK_X, {16'h0, peak});
    write_reg(REG_Z_SPREAD, {16'h0, spread});
    write_reg(REG_HOLD, hold);
    write_reg(REG_SPEED_LIMIT, {16'h0, lim});
    cur_hold  = hold;
    cur_limit = lim;
  endtask

  function automatic logic [15:0] near(input int centre, input int dev);
    return 16'(centre - dev + int'($urandom_range(0, 2 * dev)));
  endfunction

  function automatic logic [15:0] pick_speed(input int regime);
    int mag;
    mag = (cur_limit < 0) ? -int'(cur_limit) : 300;
    case (regime)
      0:       return 16'(-int'($urandom_range(0, mag)));
      1:       return 16'($urandom_range(0, 32767));
      2:       return 16'(-int'($urandom_range(mag, 32768)));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly steady progress, now and then a jump or a clock going back
  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom;
      1:       clock_ms = clock_ms - $urandom_range(1, 500);
      2:       clock_ms = clock_ms + cur_hold;
      default: clock_ms = clock_ms + $urandom_range(0, (cur_hold < 40) ? 2 * cur_hold + 2 : 80);
    endcase
    return clock_ms;
  endfunction

  task automatic push_accel();
    if ($urandom_range(0, 6) == 0)
      push_item(CMD_ACCEL, 16'($urandom), 16'($urandom), 16'($urandom), 32'($urandom));
    else
      push_item(CMD_ACCEL, 16'h0, near(0, 300), near(4096, 300), 32'h0);
  endtask

  task automatic run_directed();
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_NONE,  16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    // one sample puts the sum exactly on ten times the default limit
    push_item(CMD_SPEED, 16'hF600, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_ACCEL, 16'h0000, 16'h7FFF, 16'h7FFF, 32'd0);
    push_item(CMD_ACCEL, 16'h0000, 16'h8000, 16'h8000, 32'd0);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd100);
    push_item(CMD_SPEED, 16'h0001, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd200);
    push_item(CMD_SPEED, 16'h7FFF, 16'h0000, 16'h0000, 32'd0);
    // zero hold: kept at the onset time, dropped one ms later
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd200);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd201);
    push_item(CMD_SPEED, 16'h8000, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_SPEED, 16'h0001, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
    push_item(CMD_SPEED, 16'h7FFF, 16'h0000, 16'h0000, 32'd0);
    // elapsed time wraps through zero
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd5);
    push_item(CMD_SPEED, 16'h8000, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_SPEED, 16'h0001, 16'h0000, 16'h0000, 32'd0);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd1000);
    push_item(CMD_SPEED, 16'h7FFF, 16'h0000, 16'h0000, 32'd0);
    // clock going back reads as a long elapsed time
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd999);
    // rounding ties on both signs, then a tiny negative value
    push_item(CMD_ACCEL, 16'h0000, 16'd40, 16'hFFD8, 32'd0);
    push_item(CMD_ACCEL, 16'h0000, 16'hFFFF, 16'h0001, 32'd0);
    push_item(CMD_EVAL,  16'h0000, 16'h0000, 16'h0000, 32'd1000);
  endtask

  task automatic run_episode();
    int roll;
    int regime;
    int n_spd;
    int n_acc;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      push_item(cmd_e'(2'($urandom_range(0, 3))), 16'($urandom), 16'($urandom),
                16'($urandom), $urandom);
      return;
    end
    if (roll < 12) begin
      // refill the whole window with negative x so the peak itself goes negative
      for (int i = 0; i < ACCEL_DEPTH_DEF; i++)
        push_item(CMD_ACCEL, 16'h0, 16'(-int'($urandom_range(1, 32768))), 16'($urandom),
                  32'h0);
      push_item(CMD_EVAL, 16'h0, 16'h0, 16'h0, next_time());
      return;
    end
    regime = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
    n_spd  = $urandom_range(0, 12);
    n_acc  = $urandom_range(0, 12);
    while (n_spd + n_acc > 0) begin
      if (n_acc == 0 || (n_spd > 0 && $urandom_range(0, 1) == 1)) begin
        push_item(CMD_SPEED, pick_speed(regime), 16'($urandom), 16'($urandom), 32'h0);
        n_spd--;
      end else begin
        push_accel();
        n_acc--;
      end
    end
    push_item(CMD_EVAL, 16'($urandom), 16'($urandom), 16'($urandom), next_time());
    if ($urandom_range(0, 3) == 0) push_item(CMD_EVAL, 16'h0, 16'h0, 16'h0, next_time());
  endtask

  initial begin
    int unsigned base;
    bit          paused;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      apply_config(ph);
      calm   = (ph == 1);
      base   = sent;
      paused = 1'b0;
      while (sent - base < PHASE_ITEMS) begin
        run_episode();
        if (ph == 3 && !paused && sent - base >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end
    settle();
    if (chk_fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
